### hw/rtl/integer_table_engine_with_sort_defines.svh
// assertion helpers for the integer table engine
`ifndef INTEGER_TABLE_ENGINE_WITH_SORT_DEFINES_SVH
`define INTEGER_TABLE_ENGINE_WITH_SORT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define ITE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ite assertion failed");

// next-cycle implication, sampled on clk, off while in reset
`define ITE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ite assertion failed");

`endif

### hw/rtl/ite_pkg.sv
`timescale 1ns / 1ps

package ite_pkg;

	localparam int DEPTH   = 32;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WORD_W  = 32;
	localparam int MAX_OUT = 32;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
	localparam logic [ADDR_W-1:0] LAST_PASS = ADDR_W'(DEPTH - 2);
	localparam logic [5:0]        COUNT_MAX = 6'd63;

	// request codes
	localparam logic [2:0] REQ_WRITE  = 3'd0;
	localparam logic [2:0] REQ_DELETE = 3'd1;
	localparam logic [2:0] REQ_SEARCH = 3'd2;
	localparam logic [2:0] REQ_READ   = 3'd3;
	localparam logic [2:0] REQ_SORT   = 3'd4;

	typedef struct packed {
		logic [2:0]         req_type;
		logic [4:0]         slot;
		logic signed [31:0] word;
	} req_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic [4:0]         hit_slot;
		logic signed [31:0] read_word;
		logic [5:0]         match_count;
		logic               found;
		logic               last;
	} rsp_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [WORD_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic eq;
		logic lt;
	} cmp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACK,
		ST_READ,
		ST_DEL,
		ST_DEL_TOP,
		ST_COUNT,
		ST_EMIT,
		ST_SORT_LD,
		ST_SORT_RUN,
		ST_SORT_END
	} state_t;

endpackage

### hw/rtl/ite_mem.sv
`timescale 1ns / 1ps

module ite_mem (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ite_pkg::mem_req_t                   port,
	output logic [ite_pkg::WORD_W-1:0]          rdata
);

	logic [ite_pkg::WORD_W-1:0] mem [ite_pkg::DEPTH];
	logic [ite_pkg::DEPTH-1:0]  vld_q;
	logic [ite_pkg::WORD_W-1:0] rd_q;
	logic                       rvld_q;

	// storage, no reset
	always_ff @(posedge clk) begin
		if (port.we) begin
			mem[port.waddr] <= port.wdata;
		end
		if (port.re) begin
			rd_q <= mem[port.raddr];
		end
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (port.we) begin
				vld_q[port.waddr] <= 1'b1;
			end
			if (port.re) begin
				rvld_q <= vld_q[port.raddr];
			end
		end
	end

	assign rdata = rvld_q ? rd_q : '0;

endmodule

### hw/rtl/ite_cmp.sv
`timescale 1ns / 1ps

module ite_cmp (
	input  logic [ite_pkg::WORD_W-1:0] a,
	input  logic [ite_pkg::WORD_W-1:0] b,
	output ite_pkg::cmp_t              res
);

	// single shared comparator: equality and signed less-than
	always_comb begin
		res.eq = (a == b);
		res.lt = ($signed(a) < $signed(b));
	end

endmodule

### hw/rtl/ite_seq.sv
`timescale 1ns / 1ps

module ite_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  ite_pkg::req_t              req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output ite_pkg::rsp_t              rsp,
	output ite_pkg::mem_req_t          mem,
	input  logic [ite_pkg::WORD_W-1:0] rdata,
	output logic [ite_pkg::WORD_W-1:0] cmp_a,
	output logic [ite_pkg::WORD_W-1:0] cmp_b,
	input  ite_pkg::cmp_t              cmp
);

	ite_pkg::state_t             state_q, state_d;
	ite_pkg::req_t               req_q, req_d;
	logic [ite_pkg::ADDR_W-1:0]  idx_q, idx_d;
	logic [ite_pkg::ADDR_W-1:0]  pass_q, pass_d;
	logic [5:0]                  cnt_q, cnt_d;
	logic [5:0]                  emit_q, emit_d;
	logic [ite_pkg::WORD_W-1:0]  carry_q, carry_d;
	ite_pkg::rsp_t               rsp_q, rsp_d;
	logic                        rsp_valid_q, rsp_valid_d;

	logic                        out_free;
	logic                        in_range;
	logic [ite_pkg::ADDR_W-1:0]  slot_addr;
	logic [5:0]                  emit_next;
	logic                        emit_fin;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign slot_addr = ite_pkg::ADDR_W'(req.slot);
	assign in_range  = (32'(req.slot) < 32'(ite_pkg::DEPTH));
	assign emit_next = emit_q + 6'd1;
	assign emit_fin  = (emit_next == cnt_q) || (emit_next == 6'(ite_pkg::MAX_OUT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ite_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q   <= req_d;
		idx_q   <= idx_d;
		pass_q  <= pass_d;
		cnt_q   <= cnt_d;
		emit_q  <= emit_d;
		carry_q <= carry_d;
		rsp_q   <= rsp_d;
	end

	always_comb begin
		state_d     = state_q;
		req_d       = req_q;
		idx_d       = idx_q;
		pass_d      = pass_q;
		cnt_d       = cnt_q;
		emit_d      = emit_q;
		carry_d     = carry_q;
		rsp_d       = rsp_q;
		rsp_valid_d = rsp_valid_q && rsp_stall;
		mem         = '0;
		cmp_a       = rdata;
		cmp_b       = req_q.word;
		req_stall   = (state_q != ite_pkg::ST_IDLE);

		unique case (state_q)
			ite_pkg::ST_IDLE: begin
				if (req_valid) begin
					req_d = req;
					idx_d = '0;
					unique case (req.req_type)
						ite_pkg::REQ_WRITE: begin
							mem.we    = in_range;
							mem.waddr = slot_addr;
							mem.wdata = req.word;
							state_d   = ite_pkg::ST_ACK;
						end
						ite_pkg::REQ_DELETE: begin
							if (!in_range) begin
								state_d = ite_pkg::ST_ACK;
							end else if (slot_addr == ite_pkg::LAST_ADDR) begin
								mem.we    = 1'b1;
								mem.waddr = ite_pkg::LAST_ADDR;
								state_d   = ite_pkg::ST_ACK;
							end else begin
								mem.re    = 1'b1;
								mem.raddr = slot_addr + 1'b1;
								idx_d     = slot_addr;
								state_d   = ite_pkg::ST_DEL;
							end
						end
						ite_pkg::REQ_SEARCH: begin
							mem.re  = 1'b1;
							cnt_d   = '0;
							state_d = ite_pkg::ST_COUNT;
						end
						ite_pkg::REQ_READ: begin
							if (in_range) begin
								mem.re    = 1'b1;
								mem.raddr = slot_addr;
								state_d   = ite_pkg::ST_READ;
							end else begin
								state_d = ite_pkg::ST_ACK;
							end
						end
						ite_pkg::REQ_SORT: begin
							mem.re  = 1'b1;
							pass_d  = '0;
							state_d = ite_pkg::ST_SORT_LD;
						end
						default: begin
							state_d = ite_pkg::ST_IDLE;
						end
					endcase
				end
			end

			ite_pkg::ST_ACK: begin
				if (out_free) begin
					rsp_d.kind        = req_q.req_type;
					rsp_d.hit_slot    = (req_q.req_type == ite_pkg::REQ_SEARCH ||
						req_q.req_type == ite_pkg::REQ_SORT) ? 5'd0 : req_q.slot;
					rsp_d.read_word   = '0;
					rsp_d.match_count = '0;
					rsp_d.found       = 1'b0;
					rsp_d.last        = 1'b1;
					rsp_valid_d       = 1'b1;
					state_d           = ite_pkg::ST_IDLE;
				end
			end

			ite_pkg::ST_READ: begin
				if (out_free) begin
					rsp_d.kind        = req_q.req_type;
					rsp_d.hit_slot    = req_q.slot;
					rsp_d.read_word   = rdata;
					rsp_d.match_count = '0;
					rsp_d.found       = 1'b1;
					rsp_d.last        = 1'b1;
					rsp_valid_d       = 1'b1;
					state_d           = ite_pkg::ST_IDLE;
				end
			end

			// entry idx+1 is on rdata, move it down one place
			ite_pkg::ST_DEL: begin
				mem.we    = 1'b1;
				mem.waddr = idx_q;
				mem.wdata = rdata;
				if (idx_q + 1'b1 == ite_pkg::LAST_ADDR) begin
					state_d = ite_pkg::ST_DEL_TOP;
				end else begin
					mem.re    = 1'b1;
					mem.raddr = idx_q + 2'd2;
					idx_d     = idx_q + 1'b1;
				end
			end

			ite_pkg::ST_DEL_TOP: begin
				mem.we    = 1'b1;
				mem.waddr = ite_pkg::LAST_ADDR;
				state_d   = ite_pkg::ST_ACK;
			end

			// first search pass: count matches
			ite_pkg::ST_COUNT: begin
				if (cmp.eq && cnt_q != ite_pkg::COUNT_MAX) begin
					cnt_d = cnt_q + 6'd1;
				end
				if (idx_q == ite_pkg::LAST_ADDR) begin
					if (cnt_d == '0) begin
						state_d = ite_pkg::ST_ACK;
					end else begin
						mem.re  = 1'b1;
						idx_d   = '0;
						emit_d  = '0;
						state_d = ite_pkg::ST_EMIT;
					end
				end else begin
					mem.re    = 1'b1;
					mem.raddr = idx_q + 1'b1;
					idx_d     = idx_q + 1'b1;
				end
			end

			// second search pass: one transaction per match
			ite_pkg::ST_EMIT: begin
				if (cmp.eq) begin
					if (out_free) begin
						rsp_d.kind        = req_q.req_type;
						rsp_d.hit_slot    = 5'(idx_q);
						rsp_d.read_word   = '0;
						rsp_d.match_count = emit_fin ? cnt_q : 6'd0;
						rsp_d.found       = 1'b1;
						rsp_d.last        = emit_fin;
						rsp_valid_d       = 1'b1;
						emit_d            = emit_next;
						if (emit_fin || idx_q == ite_pkg::LAST_ADDR) begin
							state_d = ite_pkg::ST_IDLE;
						end else begin
							mem.re    = 1'b1;
							mem.raddr = idx_q + 1'b1;
							idx_d     = idx_q + 1'b1;
						end
					end
				end else if (idx_q == ite_pkg::LAST_ADDR) begin
					state_d = ite_pkg::ST_IDLE;
				end else begin
					mem.re    = 1'b1;
					mem.raddr = idx_q + 1'b1;
					idx_d     = idx_q + 1'b1;
				end
			end

			ite_pkg::ST_SORT_LD: begin
				carry_d   = rdata;
				mem.re    = 1'b1;
				mem.raddr = ite_pkg::ADDR_W'(1);
				idx_d     = ite_pkg::ADDR_W'(1);
				state_d   = ite_pkg::ST_SORT_RUN;
			end

			// bubble pass: smaller goes down, carry the larger up
			ite_pkg::ST_SORT_RUN: begin
				cmp_b     = carry_q;
				mem.we    = 1'b1;
				mem.waddr = idx_q - 1'b1;
				mem.wdata = cmp.lt ? rdata : carry_q;
				carry_d   = cmp.lt ? carry_q : rdata;
				if (idx_q == ite_pkg::LAST_ADDR) begin
					state_d = ite_pkg::ST_SORT_END;
				end else begin
					mem.re    = 1'b1;
					mem.raddr = idx_q + 1'b1;
					idx_d     = idx_q + 1'b1;
				end
			end

			ite_pkg::ST_SORT_END: begin
				mem.we    = 1'b1;
				mem.waddr = ite_pkg::LAST_ADDR;
				mem.wdata = carry_q;
				if (pass_q == ite_pkg::LAST_PASS) begin
					state_d = ite_pkg::ST_ACK;
				end else begin
					pass_d  = pass_q + 1'b1;
					mem.re  = 1'b1;
					state_d = ite_pkg::ST_SORT_LD;
				end
			end

			default: begin
				state_d = ite_pkg::ST_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### hw/rtl/integer_table_engine_with_sort.sv
`timescale 1ns / 1ps
// integer table engine: a table of DEPTH signed 32-bit entries, zero after reset
// req channel (req_valid / req_stall / req): one transaction per request,
//   write, delete, search, read or sort; unknown request codes are dropped
// rsp channel (rsp_valid / rsp_stall / rsp): result transactions, last marks
//   the final one of a request; search gives one per matching slot, or one not-found
// one request at a time: req_stall stays high until the request is done
// write and read touch one entry; delete moves each entry above the slot
//   down one place and clears the top one; search is a counting walk, then
//   a reporting walk; sort runs (DEPTH-1) bubble passes over the table
// the walks step through the table, one entry a cycle unless a search
// report waits on a stalled receiver, using one read and one write port
// and the one shared comparator
// reset clears the table (per-entry valid flags) and the sequencer at once;
// no clearing pass is needed
// a stalled receiver holds the result register; the walk then waits on it
// and resumes with no transaction lost or repeated

`include "integer_table_engine_with_sort_defines.svh"

module integer_table_engine_with_sort (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ite_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ite_pkg::rsp_t rsp
);

	// table port requests from the sequencer
	ite_pkg::mem_req_t          mem_port;
	logic [ite_pkg::WORD_W-1:0] mem_rdata;

	// shared comparator operands and result
	logic [ite_pkg::WORD_W-1:0] cmp_a;
	logic [ite_pkg::WORD_W-1:0] cmp_b;
	ite_pkg::cmp_t              cmp_res;

	// table storage, registered read
	ite_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.port   (mem_port),
		.rdata  (mem_rdata)
	);

	// compare unit used by search (equality) and sort (signed order)
	ite_cmp u_cmp (
		.a   (cmp_a),
		.b   (cmp_b),
		.res (cmp_res)
	);

	// sequencer with the result register
	ite_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.mem       (mem_port),
		.rdata     (mem_rdata),
		.cmp_a     (cmp_a),
		.cmp_b     (cmp_b),
		.cmp       (cmp_res)
	);

	// an accepted known request leaves the block busy in the cycle after
	`ITE_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall && req.req_type <= ite_pkg::REQ_SORT, req_stall)

	// every non-search result is a single final transaction with no count
	`ITE_ASSERT_NOW(a_single_ack, rsp_valid && rsp.kind != ite_pkg::REQ_SEARCH, rsp.last && rsp.match_count == 6'd0)

	// a final search hit always reports a nonzero count
	`ITE_ASSERT_NOW(a_search_count, rsp_valid && rsp.kind == ite_pkg::REQ_SEARCH && rsp.found && rsp.last, rsp.match_count != 6'd0)

endmodule

### tb/sv/integer_table_engine_with_sort_tb.sv
`timescale 1ns / 1ps

module integer_table_engine_with_sort_tb;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	ite_pkg::req_t req;
	logic rsp_valid;
	logic rsp_stall;
	ite_pkg::rsp_t rsp;

	// shadow copy of the table, kept in step with every accepted request
	logic signed [ite_pkg::WORD_W-1:0] shadow_tab [ite_pkg::DEPTH];
	// results still owed by the block, oldest first
	ite_pkg::rsp_t pending_rsp [$];
	int mismatch_count;
	// while set, neither side inserts gaps or stalls
	bit calm;
	int stall_left;

	integer_table_engine_with_sort i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop, well beyond the slowest legal run (sorts and long stalls included)
	initial begin
		#30_000_000;
		$display("[integer_table_engine_with_sort] ERROR");
		$finish;
	end

	// gap length: mostly none, often short, now and then long
	function automatic int pick_gap();
		if (calm)
			return 0;
		if ($urandom_range(0, 9) < 6)
			return 0;
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// word values lean towards a small pool so that searches hit repeatedly
	function automatic logic signed [ite_pkg::WORD_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return -32'sd1;
			3: return 32'sd0;
			4, 5: return $urandom();
			default: return $signed($urandom_range(0, 4)) - 32'sd2;
		endcase
	endfunction

	function automatic void owe_result(input logic [2:0] kind, input logic [4:0] hit,
			input logic signed [ite_pkg::WORD_W-1:0] rword, input logic [5:0] count,
			input logic found, input logic last);
		ite_pkg::rsp_t r;
		r.kind        = kind;
		r.hit_slot    = hit;
		r.read_word   = rword;
		r.match_count = count;
		r.found       = found;
		r.last        = last;
		pending_rsp.push_back(r);
	endfunction

	// apply one accepted request to the shadow table and queue what it must return
	function automatic void apply_to_shadow(input ite_pkg::req_t item);
		int i;
		int j;
		int n;
		int total;
		logic signed [ite_pkg::WORD_W-1:0] v;
		bit in_range;
		bit fin;
		in_range = item.slot < ite_pkg::DEPTH;
		case (item.req_type)
			ite_pkg::REQ_WRITE: begin
				if (in_range)
					shadow_tab[item.slot] = item.word;
				owe_result(ite_pkg::REQ_WRITE, item.slot, '0, '0, 1'b0, 1'b1);
			end
			ite_pkg::REQ_DELETE: begin
				if (in_range) begin
					for (i = item.slot; i < ite_pkg::DEPTH - 1; i++)
						shadow_tab[i] = shadow_tab[i + 1];
					shadow_tab[ite_pkg::DEPTH - 1] = '0;
				end
				owe_result(ite_pkg::REQ_DELETE, item.slot, '0, '0, 1'b0, 1'b1);
			end
			ite_pkg::REQ_SEARCH: begin
				total = 0;
				for (i = 0; i < ite_pkg::DEPTH; i++)
					if (shadow_tab[i] == item.word)
						total++;
				if (total == 0) begin
					// nothing matched: a single not-found transaction
					owe_result(ite_pkg::REQ_SEARCH, '0, '0, '0, 1'b0, 1'b1);
				end else begin
					if (total > ite_pkg::COUNT_MAX)
						total = ite_pkg::COUNT_MAX;
					n = 0;
					for (i = 0; i < ite_pkg::DEPTH && n < ite_pkg::MAX_OUT; i++) begin
						if (shadow_tab[i] == item.word) begin
							fin = (n + 1 == total) || (n + 1 == ite_pkg::MAX_OUT);
							owe_result(ite_pkg::REQ_SEARCH, 5'(i), '0,
								fin ? 6'(total) : 6'd0, 1'b1, fin);
							n++;
						end
					end
				end
			end
			ite_pkg::REQ_READ: begin
				if (in_range)
					owe_result(ite_pkg::REQ_READ, item.slot, shadow_tab[item.slot], '0,
						1'b1, 1'b1);
				else
					owe_result(ite_pkg::REQ_READ, item.slot, '0, '0, 1'b0, 1'b1);
			end
			ite_pkg::REQ_SORT: begin
				// ascending signed order
				for (i = 1; i < ite_pkg::DEPTH; i++) begin
					v = shadow_tab[i];
					j = i;
					while (j > 0 && v < shadow_tab[j - 1]) begin
						shadow_tab[j] = shadow_tab[j - 1];
						j--;
					end
					shadow_tab[j] = v;
				end
				owe_result(ite_pkg::REQ_SORT, '0, '0, '0, 1'b0, 1'b1);
			end
			default: ; // unknown request codes are dropped silently
		endcase
	endfunction

	function automatic void check_result(input ite_pkg::rsp_t got);
		ite_pkg::rsp_t want;
		if (pending_rsp.size() == 0) begin
			$display("%0t: unexpected result, got kind %0d slot %0d word %0d count %0d found %0b last %0b",
				$time, got.kind, got.hit_slot, got.read_word, got.match_count, got.found,
				got.last);
			mismatch_count++;
			return;
		end
		want = pending_rsp.pop_front();
		if (got !== want) begin
			$display("%0t: result mismatch, expected kind %0d slot %0d word %0d count %0d found %0b last %0b",
				$time, want.kind, want.hit_slot, want.read_word, want.match_count, want.found,
				want.last);
			$display("%0t:                  actual   kind %0d slot %0d word %0d count %0d found %0b last %0b",
				$time, got.kind, got.hit_slot, got.read_word, got.match_count, got.found,
				got.last);
			mismatch_count++;
		end
	endfunction

	// result side: check each accepted transaction, then choose the next stall
	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
			check_result(rsp);
		if (stall_left > 0) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else begin
			stall_left = pick_gap();
			if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// one request transaction; valid only drops when a gap precedes this one,
	// so back-to-back requests never see valid lowered and raised in one step
	task automatic send_request(input logic [2:0] op, input logic [4:0] where,
			input logic signed [ite_pkg::WORD_W-1:0] w);
		int gap;
		ite_pkg::req_t item;
		item.req_type = op;
		item.slot     = where;
		item.word     = w;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall !== 1'b0)
			@(posedge clk);
		apply_to_shadow(item);
	endtask

	// let everything owed come back, then a margin for a late or spurious result
	task automatic wait_idle();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (2 * ite_pkg::DEPTH + 4) @(posedge clk);
	endtask

	// table straight out of reset: all zero, so a search for zero hits every slot
	task automatic test_reset_contents();
		send_request(ite_pkg::REQ_READ, 5'd0, 32'sd0);
		send_request(ite_pkg::REQ_READ, ite_pkg::LAST_ADDR, 32'sd0);
		send_request(ite_pkg::REQ_SEARCH, 5'd0, 32'sd0);
	endtask

	// extremes of the word and slot fields, a single hit and a miss
	task automatic test_write_extremes();
		send_request(ite_pkg::REQ_WRITE, 5'd0, 32'sh8000_0000);
		send_request(ite_pkg::REQ_WRITE, ite_pkg::LAST_ADDR, 32'sh7fff_ffff);
		send_request(ite_pkg::REQ_WRITE, 5'd17, -32'sd1);
		send_request(ite_pkg::REQ_WRITE, 5'd10, 32'sh5555_5555);
		send_request(ite_pkg::REQ_READ, 5'd0, 32'sd0);
		send_request(ite_pkg::REQ_READ, ite_pkg::LAST_ADDR, 32'sd0);
		send_request(ite_pkg::REQ_READ, 5'd17, 32'sd0);
		send_request(ite_pkg::REQ_SEARCH, 5'd0, 32'sh7fff_ffff);
		send_request(ite_pkg::REQ_SEARCH, 5'd0, 32'sh1234_abcd);
		send_request(ite_pkg::REQ_SEARCH, ite_pkg::LAST_ADDR, 32'sh8000_0000);
	endtask

	// delete at the bottom, at the top and in the middle; the top must refill with zero
	task automatic test_delete_shift();
		send_request(ite_pkg::REQ_DELETE, 5'd0, 32'sd0);
		send_request(ite_pkg::REQ_DELETE, ite_pkg::LAST_ADDR, 32'sd0);
		send_request(ite_pkg::REQ_DELETE, 5'd8, 32'sd0);
		send_request(ite_pkg::REQ_READ, ite_pkg::LAST_PASS, 32'sd0);
		send_request(ite_pkg::REQ_READ, ite_pkg::LAST_ADDR, 32'sd0);
	endtask

	task automatic test_sort_order();
		send_request(ite_pkg::REQ_SORT, 5'd0, 32'sd0);
		send_request(ite_pkg::REQ_READ, 5'd0, 32'sd0);
		send_request(ite_pkg::REQ_READ, ite_pkg::LAST_ADDR, 32'sd0);
	endtask

	// unused request codes: no transaction back and the table untouched
	task automatic test_unknown_codes();
		for (int c = ite_pkg::REQ_SORT + 1; c < (1 << $bits(req.req_type)); c++)
			send_request(3'(c), 5'($urandom_range(0, ite_pkg::DEPTH - 1)), $urandom());
		send_request(ite_pkg::REQ_READ, 5'd1, 32'sd0);
	endtask

	// mostly sensible traffic over a small set of values so that searches find
	// several matches; a slice of full-range words and unused codes as noise
	task automatic test_random_traffic(input int count);
		int sent;
		int roll;
		logic [4:0] where;
		logic signed [ite_pkg::WORD_W-1:0] w;
		sent = 0;
		while (sent < count) begin
			// every third block of 40 requests runs with no gaps on either side
			calm  = ((sent / 40) % 3) == 2;
			roll  = $urandom_range(0, 99);
			where = 5'($urandom_range(0, ite_pkg::DEPTH - 1));
			w     = pick_word();
			if (roll < 35) begin
				send_request(ite_pkg::REQ_WRITE, where, w);
			end else if (roll < 55) begin
				send_request(ite_pkg::REQ_READ, where, w);
			end else if (roll < 75) begin
				// half the searches look for a word that is in the table
				if ($urandom_range(0, 1))
					w = shadow_tab[$urandom_range(0, ite_pkg::DEPTH - 1)];
				send_request(ite_pkg::REQ_SEARCH, where, w);
			end else if (roll < 87) begin
				send_request(ite_pkg::REQ_DELETE, where, w);
			end else if (roll < 93) begin
				send_request(ite_pkg::REQ_SORT, where, w);
			end else begin
				send_request(3'(ite_pkg::REQ_SORT + 1 + $urandom_range(0, 2)), where, w);
				sent--;
			end
			sent++;
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n         = 1'b0;
		req_valid      = 1'b0;
		req            = '0;
		rsp_stall      = 1'b0;
		stall_left     = 0;
		calm           = 1'b0;
		mismatch_count = 0;
		for (int i = 0; i < ite_pkg::DEPTH; i++)
			shadow_tab[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_contents();
		test_write_extremes();
		test_delete_shift();
		test_sort_order();
		test_unknown_codes();
		wait_idle();

		test_random_traffic(170);
		wait_idle();

		if (mismatch_count == 0) begin
			$display("[integer_table_engine_with_sort] OK");
		end else begin
			$display("[integer_table_engine_with_sort] ERROR");
		end
		$finish;
	end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/ite_pkg.sv
hw/rtl/ite_mem.sv
hw/rtl/ite_cmp.sv
hw/rtl/ite_seq.sv
hw/rtl/integer_table_engine_with_sort.sv
tb/sv/integer_table_engine_with_sort_tb.sv
